// ----- rtl/vbp_pkg.sv -----
// ----------------------------------------------------------------------------
// vbp_pkg
// Shared types and constants of the vertical bit packer: beat layouts,
// lane count and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package vbp_pkg;

  // values carried by one input beat, also words carried by one result beat
  localparam int LANES = 4;
  localparam int LIDX = $clog2(LANES);
  localparam int WORD_BITS = 32;
  localparam int WIDTH_BITS = 6;
  localparam int VALID_BITS = 3;
  localparam int HEADER_WORDS = 2;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VALUE_COUNT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VALUE_WIDTH = 2'd1;

  // input beat
  typedef struct packed {
    logic [WORD_BITS-1:0] value_0;
    logic [WORD_BITS-1:0] value_1;
    logic [WORD_BITS-1:0] value_2;
    logic [WORD_BITS-1:0] value_3;
  } item_t;

  // result beat
  typedef struct packed {
    logic [WORD_BITS-1:0]  word_0;
    logic [WORD_BITS-1:0]  word_1;
    logic [WORD_BITS-1:0]  word_2;
    logic [WORD_BITS-1:0]  word_3;
    logic [VALID_BITS-1:0] words_valid;
    logic                  value_too_wide;
    logic                  last_of_run;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/vbp_lane.sv -----
// ----------------------------------------------------------------------------
// vbp_lane
// One packing lane: masks its value, checks it against the width, shifts it
// into its slot and hands the row/slot of the following position onward.
// ----------------------------------------------------------------------------
`default_nettype none

module vbp_lane #(
  parameter int AW = 7,
  parameter int RW = 8
) (
  input  logic [AW-1:0]                 row_in,
  input  logic [AW-1:0]                 slot_in,
  input  logic [RW-1:0]                 rows,
  input  logic [4:0]                    width,
  input  logic [vbp_pkg::WORD_BITS-1:0] mask,
  input  logic [vbp_pkg::WORD_BITS-1:0] value,
  input  logic                          active,
  output logic [AW-1:0]                 row_next,
  output logic [AW-1:0]                 slot_next,
  output logic [vbp_pkg::WORD_BITS-1:0] word,
  output logic                          too_wide
);

  logic [RW-1:0] row_inc;
  logic          wrap;
  logic [9:0]    prod;
  logic [4:0]    shift;

  // step to the next position: next row, wrapping into the next slot
  assign row_inc   = RW'(row_in) + RW'(1);
  assign wrap      = (row_inc == rows);
  assign row_next  = wrap ? '0 : row_inc[AW-1:0];
  assign slot_next = wrap ? slot_in + AW'(1) : slot_in;

  // bit offset is width * slot modulo the word size
  assign prod  = {5'b0, width} * {5'b0, slot_in[4:0]};
  assign shift = prod[4:0];

  // masked and placed value
  assign word     = active ? ((value & mask) << shift) : '0;
  assign too_wide = active && (|(value & ~mask));

endmodule

`default_nettype wire

// ----- rtl/vbp_merge.sv -----
// ----------------------------------------------------------------------------
// vbp_merge
// Combines lane contributions that land in the same row, so that each row
// touched by a beat is written once.
// ----------------------------------------------------------------------------
`default_nettype none

module vbp_merge #(
  parameter int AW = 7
) (
  input  logic [AW-1:0]                 row    [vbp_pkg::LANES],
  input  logic [vbp_pkg::WORD_BITS-1:0] word   [vbp_pkg::LANES],
  input  logic                          act    [vbp_pkg::LANES],
  output logic                          keep   [vbp_pkg::LANES],
  output logic [vbp_pkg::WORD_BITS-1:0] merged [vbp_pkg::LANES]
);

  // first active lane of a row keeps the write and collects the others
  always_comb begin
    for (int i = 0; i < vbp_pkg::LANES; i++) begin
      keep[i]   = act[i];
      merged[i] = '0;
      for (int k = 0; k < i; k++) begin
        if (act[k] && (row[k] == row[i])) begin
          keep[i] = 1'b0;
        end
      end
      for (int j = i; j < vbp_pkg::LANES; j++) begin
        if (act[j] && (row[j] == row[i])) begin
          merged[i] = merged[i] | word[j];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/vbp_div.sv -----
// ----------------------------------------------------------------------------
// vbp_div
// Restoring divider, one quotient bit per cycle. Recovers row and slot of the
// current block position when the row count changes inside a block.
// ----------------------------------------------------------------------------
`default_nettype none

module vbp_div #(
  parameter int NW = 7,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [NW-1:0] nsh;
  logic [DW:0]   trial;
  logic          ge;

  // trial subtraction of the next numerator bit
  assign trial = {rem, nsh[NW-1]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // done pulses with the last quotient bit
      done <= !go && run && (cnt == CW'(1));
      if (go) begin
        run <= 1'b1;
        cnt <= CW'(NW);
        nsh <= num;
        rem <= '0;
        quo <= '0;
      end else if (run) begin
        rem <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
        quo <= {quo[NW-2:0], ge};
        nsh <= nsh << 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/vertical_bit_pack_128.sv -----
// ----------------------------------------------------------------------------
// vertical_bit_pack_128
// Vertical bit packer: four values per beat are masked, placed by four lanes
// and OR-merged into a row store; blocks are flushed up to four words a beat.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. It then occupies the
// block while the four lanes place its values and during the read-modify-write
// of the touched rows through the row store, which has one read port and one
// write port. After its write, the first item after reset also sends the
// header beat. If a width change in the middle of a block alters the row
// count, the row and slot of the current position are first recomputed by the
// divider. An item that ends a block is followed by the flush, which reads
// and clears max(rows, rows used in the block) rows of the store, one row per
// cycle; rows = ceil(BLOCK_VALUES / (32 / width)). After reset the store is
// cleared while busy is high; configuration writes are always taken. Results
// come one beat per cycle at most, each shown for one cycle with result_valid;
// the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

module vertical_bit_pack_128 #(
  parameter int BLOCK_VALUES = 128
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  vbp_pkg::item_t                       item,
  output vbp_pkg::result_t                     result,
  output logic                                 result_valid,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vbp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [vbp_pkg::WORD_BITS-1:0]        cfg_data
);

  localparam int AW    = $clog2(BLOCK_VALUES);
  localparam int RW    = $clog2(BLOCK_VALUES + 1);
  localparam int LN    = vbp_pkg::LANES;
  localparam int LIDX  = vbp_pkg::LIDX;
  localparam int WB    = vbp_pkg::WORD_BITS;

  // row counts for each values-per-word figure
  localparam logic [RW-1:0] ROWS_PW32 = RW'((BLOCK_VALUES + 31) / 32);
  localparam logic [RW-1:0] ROWS_PW16 = RW'((BLOCK_VALUES + 15) / 16);
  localparam logic [RW-1:0] ROWS_PW10 = RW'((BLOCK_VALUES + 9) / 10);
  localparam logic [RW-1:0] ROWS_PW8  = RW'((BLOCK_VALUES + 7) / 8);
  localparam logic [RW-1:0] ROWS_PW6  = RW'((BLOCK_VALUES + 5) / 6);
  localparam logic [RW-1:0] ROWS_PW5  = RW'((BLOCK_VALUES + 4) / 5);
  localparam logic [RW-1:0] ROWS_PW4  = RW'((BLOCK_VALUES + 3) / 4);
  localparam logic [RW-1:0] ROWS_PW3  = RW'((BLOCK_VALUES + 2) / 3);
  localparam logic [RW-1:0] ROWS_PW2  = RW'((BLOCK_VALUES + 1) / 2);
  localparam logic [RW-1:0] ROWS_PW1  = RW'(BLOCK_VALUES);

  // sequencer states
  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_LANE  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_HDR   = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  function automatic logic [RW-1:0] rows_for(input logic [5:0] w);
    logic [RW-1:0] r;
    case (w) inside
      6'd1:            r = ROWS_PW32;
      6'd2:            r = ROWS_PW16;
      6'd3:            r = ROWS_PW10;
      6'd4:            r = ROWS_PW8;
      6'd5:            r = ROWS_PW6;
      6'd6:            r = ROWS_PW5;
      [6'd7:6'd8]:     r = ROWS_PW4;
      [6'd9:6'd10]:    r = ROWS_PW3;
      [6'd11:6'd16]:   r = ROWS_PW2;
      default:         r = ROWS_PW1;
    endcase
    return r;
  endfunction

  // configuration registers
  logic [WB-1:0]                  value_count;
  logic [vbp_pkg::WIDTH_BITS-1:0] value_width;

  // control state
  logic [2:0]          state;
  logic [RW-1:0]       fc;
  logic [RW-1:0]       pos;
  logic [WB-1:0]       seen;
  logic                header_sent;
  logic                too_wide;
  logic [RW-1:0]       hw;
  logic [AW-1:0]       base_row;
  logic [AW-1:0]       base_slot;
  logic [RW-1:0]       rows_reg;
  logic                flush_pend;
  logic [LIDX:0]       wi;
  logic [LIDX-1:0]     gl;

  // payload registers
  logic [WB-1:0]       val      [LN];
  logic [AW-1:0]       wr_row   [LN];
  logic [WB-1:0]       wr_word  [LN];
  logic                wr_keep  [LN];
  logic [WB-1:0]       grp      [LN];

  // row store
  logic [WB-1:0]       mem      [BLOCK_VALUES];
  logic [WB-1:0]       rd_data;
  logic                mem_rd;
  logic [AW-1:0]       mem_raddr;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [WB-1:0]       mem_wdata;

  // derived values
  logic [5:0]          weff;
  logic [WB-1:0]       mask;
  logic [RW-1:0]       rows_now;
  logic                accept;
  logic                need_div;
  logic [WB-1:0]       rem_cnt;
  logic [RW-1:0]       room;
  logic [2:0]          n_a;
  logic [2:0]          n_act;
  logic [RW-1:0]       pos_new;
  logic [WB-1:0]       seen_new;
  logic                flush_c;
  logic [RW-1:0]       clr_len;
  logic [RW-1:0]       q;
  logic                fl_emit;
  logic [WB-1:0]       fl_word  [LN];
  logic [LIDX-1:0]     wi_lo;
  logic [LIDX-1:0]     wi_m1;

  // lane chain
  logic [AW-1:0]       ch_row   [LN+1];
  logic [AW-1:0]       ch_slot  [LN+1];
  logic [AW-1:0]       lane_row [LN];
  logic [WB-1:0]       lane_word[LN];
  logic                lane_act [LN];
  logic                lane_wide[LN];
  logic                keep_c   [LN];
  logic [WB-1:0]       merged_c [LN];
  logic                any_wide;

  // divider
  logic                div_done;
  logic [AW-1:0]       div_quo;
  logic [RW-1:0]       div_rem;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  // effective width and mask
  always_comb begin
    if (value_width == 6'd0) begin
      weff = 6'd1;
    end else if (value_width > 6'd32) begin
      weff = 6'd32;
    end else begin
      weff = value_width;
    end
  end
  assign mask     = (weff == 6'd32) ? '1 : ((WB'(1) << weff[4:0]) - WB'(1));
  assign rows_now = rows_for(weff);
  assign need_div = (pos != '0) && (rows_now != rows_reg);

  // number of values this beat places
  assign rem_cnt  = (seen >= value_count) ? '0 : (value_count - seen);
  assign room     = RW'(BLOCK_VALUES) - pos;
  assign n_a      = (rem_cnt < WB'(LN)) ? rem_cnt[2:0] : 3'(LN);
  assign n_act    = (room < RW'(n_a)) ? room[2:0] : n_a;
  assign pos_new  = pos + RW'(n_act);
  assign seen_new = seen + WB'(n_act);
  assign flush_c  = (pos_new >= RW'(BLOCK_VALUES)) ||
                    ((pos_new != '0) && (seen_new >= value_count));
  assign clr_len  = (hw > rows_now) ? hw : rows_now;

  // packing lanes
  assign ch_row[0]  = base_row;
  assign ch_slot[0] = base_slot;

  for (genvar i = 0; i < LN; i++) begin : g_lane
    assign lane_act[i] = (3'(i) < n_act);
    assign lane_row[i] = ch_row[i];
    vbp_lane #(
      .AW(AW),
      .RW(RW)
    ) u_lane (
      .row_in   (ch_row[i]),
      .slot_in  (ch_slot[i]),
      .rows     (rows_now),
      .width    (weff[4:0]),
      .mask     (mask),
      .value    (val[i]),
      .active   (lane_act[i]),
      .row_next (ch_row[i+1]),
      .slot_next(ch_slot[i+1]),
      .word     (lane_word[i]),
      .too_wide (lane_wide[i])
    );
  end

  always_comb begin
    any_wide = 1'b0;
    for (int i = 0; i < LN; i++) begin
      any_wide = any_wide | lane_wide[i];
    end
  end

  // same-row merge
  vbp_merge #(
    .AW(AW)
  ) u_merge (
    .row   (lane_row),
    .word  (lane_word),
    .act   (lane_act),
    .keep  (keep_c),
    .merged(merged_c)
  );

  // position recovery after a width change
  vbp_div #(
    .NW(AW),
    .DW(RW)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .go  (accept && need_div),
    .num (pos[AW-1:0]),
    .den (rows_now),
    .done(div_done),
    .quo (div_quo),
    .rem (div_rem)
  );

  // flush grouping
  assign q       = fc - RW'(1);
  assign fl_emit = (gl == LIDX'(LN - 1)) || (q == rows_now - RW'(1));
  always_comb begin
    for (int j = 0; j < LN; j++) begin
      if (LIDX'(j) < gl) begin
        fl_word[j] = grp[j];
      end else if (LIDX'(j) == gl) begin
        fl_word[j] = rd_data;
      end else begin
        fl_word[j] = '0;
      end
    end
  end

  assign wi_lo = wi[LIDX-1:0];
  assign wi_m1 = wi_lo - LIDX'(1);

  // row store port control
  always_comb begin
    mem_rd    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = fc[AW-1:0];
      end
      S_WRITE: begin
        if (wi < (LIDX+1)'(LN)) begin
          mem_rd    = wr_keep[wi_lo];
          mem_raddr = wr_row[wi_lo];
        end
        if ((wi != '0) && wr_keep[wi_m1]) begin
          mem_we    = 1'b1;
          mem_waddr = wr_row[wi_m1];
          mem_wdata = rd_data | wr_word[wi_m1];
        end
      end
      S_FLUSH: begin
        if (fc < clr_len) begin
          mem_rd    = 1'b1;
          mem_raddr = fc[AW-1:0];
          mem_we    = 1'b1;
          mem_waddr = fc[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // row store, registered read
  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_data <= mem[mem_raddr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      value_count <= WB'(1);
      value_width <= 6'd32;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vbp_pkg::REG_VALUE_COUNT: value_count <= cfg_data;
        vbp_pkg::REG_VALUE_WIDTH: value_width <= cfg_data[vbp_pkg::WIDTH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (accept) begin
      val[0] <= item.value_0;
      val[1] <= item.value_1;
      val[2] <= item.value_2;
      val[3] <= item.value_3;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      fc           <= '0;
      pos          <= '0;
      seen         <= '0;
      header_sent  <= 1'b0;
      too_wide     <= 1'b0;
      hw           <= '0;
      base_row     <= '0;
      base_slot    <= '0;
      rows_reg     <= '0;
      flush_pend   <= 1'b0;
      wi           <= '0;
      gl           <= '0;
      result_valid <= 1'b0;
    end else begin
      // a beat leaves on the header or on a completed flush group
      result_valid <= (state == S_HDR) ||
                      ((state == S_FLUSH) && (fc != '0) && (q < rows_now) && fl_emit);
      unique case (state)
        S_INIT: begin
          if (fc == RW'(BLOCK_VALUES - 1)) begin
            fc    <= '0;
            state <= S_IDLE;
          end else begin
            fc <= fc + RW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= need_div ? S_DIV : S_LANE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            base_row  <= div_rem[AW-1:0];
            base_slot <= div_quo;
            rows_reg  <= rows_now;
            state     <= S_LANE;
          end
        end
        S_LANE: begin
          for (int i = 0; i < LN; i++) begin
            wr_row[i]  <= lane_row[i];
            wr_word[i] <= merged_c[i];
            wr_keep[i] <= keep_c[i];
          end
          pos        <= pos_new;
          seen       <= seen_new;
          too_wide   <= too_wide | any_wide;
          base_row   <= ch_row[n_act];
          base_slot  <= ch_slot[n_act];
          rows_reg   <= rows_now;
          flush_pend <= flush_c;
          if ((n_act != 3'd0) && (rows_now > hw)) begin
            hw <= rows_now;
          end
          wi    <= '0;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (wi == (LIDX+1)'(LN)) begin
            fc <= '0;
            gl <= '0;
            if (!header_sent) begin
              state <= S_HDR;
            end else if (flush_pend) begin
              state <= S_FLUSH;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            wi <= wi + (LIDX+1)'(1);
          end
        end
        S_HDR: begin
          result.word_0         <= value_count;
          result.word_1         <= WB'(weff);
          result.word_2         <= '0;
          result.word_3         <= '0;
          result.words_valid    <= vbp_pkg::VALID_BITS'(vbp_pkg::HEADER_WORDS);
          result.value_too_wide <= too_wide;
          result.last_of_run    <= !flush_pend;
          header_sent           <= 1'b1;
          state                 <= flush_pend ? S_FLUSH : S_IDLE;
        end
        S_FLUSH: begin
          // previous row read is back: collect it or send a beat
          if ((fc != '0) && (q < rows_now)) begin
            if (fl_emit) begin
              result.word_0         <= fl_word[0];
              result.word_1         <= fl_word[1];
              result.word_2         <= fl_word[2];
              result.word_3         <= fl_word[3];
              result.words_valid    <= vbp_pkg::VALID_BITS'(gl) + vbp_pkg::VALID_BITS'(1);
              result.value_too_wide <= too_wide;
              result.last_of_run    <= (q == rows_now - RW'(1));
              gl                    <= '0;
            end else begin
              grp[gl] <= rd_data;
              gl      <= gl + LIDX'(1);
            end
          end
          if (fc == clr_len) begin
            pos       <= '0;
            hw        <= '0;
            base_row  <= '0;
            base_slot <= '0;
            state     <= S_IDLE;
          end else begin
            fc <= fc + RW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // header always leads the result stream
  a_header_first: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> header_sent)
    else $error("result beat before header");

  // nothing follows the final beat of an item in the next cycle
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_of_run) |=> !result_valid)
    else $error("result beat right after last_of_run");

  // block position stays inside the block
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= RW'(BLOCK_VALUES))
    else $error("block position out of range");

  // merged lanes never read a row that is being written in the same cycle
  a_rmw_clash: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WRITE) && mem_rd && mem_we) |-> (mem_raddr != mem_waddr))
    else $error("row store read and write collide");

  // a result beat carries between one and four words
  a_words_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.words_valid != '0) &&
                      (result.words_valid <= vbp_pkg::VALID_BITS'(LN))))
    else $error("bad words_valid");

endmodule

`default_nettype wire
